FILE: hdl/ita_pkg.sv
// Shared types, codes and helpers for the integer to ASCII digit converter.
`timescale 1ns / 1ps

package ita_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int DATA_W          = 64;
  localparam int USER_W          = 3;
  localparam int CHAR_W          = 8;

  localparam logic [1:0] OP_SDEC  = 2'd0;
  localparam logic [1:0] OP_UDEC  = 2'd1;
  localparam logic [1:0] OP_HEX_L = 2'd2;
  localparam logic [1:0] OP_HEX_U = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  // Control handed from the sequencer to the character emitter.
  typedef struct packed {
    logic load;
    logic neg;
    logic upper;
  } emit_ctl_t;

  // Maps one digit to its ASCII code; letters follow the chosen case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = (upper ? CHAR_UPPER : CHAR_LOWER) + ext - 8'd10;
    end
  endfunction

endpackage

FILE: hdl/integer_to_ascii_digits.sv
// Top level of the integer to ASCII digit converter.
`timescale 1ns / 1ps

// Usage: the slave channel takes one number per beat. s_tdata carries the raw
// value, and s_tuser selects the conversion: bits [1:0] pick signed decimal,
// unsigned decimal, lowercase hex or uppercase hex, and bit 2 picks the full
// width for the decimal modes (otherwise the low 32 bits are used). The master
// channel returns one ASCII character per beat, most significant digit first,
// with a leading minus sign for negative signed values and tlast on the final
// digit. Leading zeros are suppressed, and zero comes out as a single '0'.
// Flow: a decimal number passes through the bit-serial BCD converter, which
// shifts one bit of the operand per cycle (32 or VALUE_WIDTH bits in all) and
// then hands the digits over; a hex number goes straight to the emitter. The
// emitter drops the suppressed leading zeros (up to 19 for a 64-bit value) one
// at a time, then sends the characters. s_tready is high only between numbers;
// the output register lets the next number be accepted while the final
// character still waits, and a stalled receiver holds the current beat and
// pauses the emitter. Reset empties the output register and idles all.
module integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ita_pkg::DATA_W-1:0]   s_tdata,   // [63:0] value
  input  logic [ita_pkg::USER_W-1:0]   s_tuser,   // [1:0] op, [2] wide
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ita_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] ascii_char
  output logic                         m_tlast
);

  localparam int W    = VALUE_WIDTH;
  // Enough decimal digits for the largest W-bit magnitude.
  localparam int NDIG = (W * 30103) / 100000 + 1;
  localparam int DW   = NDIG * 4;
  localparam int CNTW = $clog2(W + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} top_state_t;

  top_state_t         state;
  logic               neg_r;
  logic               accept;
  logic [1:0]         op_in;
  logic               wide_in;
  logic               is_hex;
  logic               sign_in;
  logic [W-1:0]       masked;
  logic [W-1:0]       negated;
  logic [W-1:0]       mag;
  logic [W-1:0]       opnd;
  logic [CNTW-1:0]    nbits;
  logic               conv_start;
  logic               conv_done;
  logic [DW-1:0]      bcd;
  logic [DW-1:0]      emit_digits;
  logic               emit_busy;
  ita_pkg::emit_ctl_t ctl;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op_in    = s_tuser[1:0];
  assign wide_in  = s_tuser[2];
  assign is_hex   = (op_in == ita_pkg::OP_HEX_L) || (op_in == ita_pkg::OP_HEX_U);

  // Operand preparation: cut to the used width, take the sign bit, and form
  // the two's complement magnitude. In the narrow mode the 32-bit operand is
  // left-aligned so that the serial converter always starts from the top bit.
  always_comb begin
    masked  = wide_in ? s_tdata[W-1:0] : {{(W-32){1'b0}}, s_tdata[31:0]};
    sign_in = (op_in == ita_pkg::OP_SDEC) && (wide_in ? s_tdata[W-1] : s_tdata[31]);
    negated = ~masked + 1'b1;
    if (sign_in) begin
      mag = wide_in ? negated : {{(W-32){1'b0}}, negated[31:0]};
    end else begin
      mag = masked;
    end
    opnd  = wide_in ? mag : (mag << (W - 32));
    nbits = wide_in ? CNTW'(W) : CNTW'(32);
  end

  assign conv_start = accept && !is_hex;

  // Hex digits are the value's nibbles as they stand; decimal digits come from
  // the converter once it finishes.
  always_comb begin
    ctl.load  = (accept && is_hex) || conv_done;
    ctl.neg   = conv_done && neg_r;
    ctl.upper = (op_in == ita_pkg::OP_HEX_U);
    emit_digits = conv_done ? bcd : {{(DW-W){1'b0}}, s_tdata[W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      neg_r <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            neg_r <= sign_in;
            state <= is_hex ? ST_EMIT : ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!emit_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ita_dabble #(
    .W    (W),
    .NDIG (NDIG),
    .CNTW (CNTW)
  ) u_dabble (
    .clk     (clk),
    .rst     (rst),
    .start   (conv_start),
    .opnd_in (opnd),
    .nbits   (nbits),
    .done    (conv_done),
    .bcd     (bcd)
  );

  ita_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .digits_in (emit_digits),
    .busy      (emit_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: hdl/ita_dabble.sv
// Bit-serial binary to BCD converter using the shift-and-add-three method.
`timescale 1ns / 1ps

module ita_dabble #(
  parameter int W    = ita_pkg::VALUE_WIDTH_DEF,
  parameter int NDIG = 20,
  parameter int CNTW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [W-1:0]      opnd_in,
  input  logic [CNTW-1:0]   nbits,
  output logic              done,
  output logic [NDIG*4-1:0] bcd
);

  logic [W-1:0]      opnd;
  logic [CNTW-1:0]   cnt;
  logic              busy;
  logic [NDIG*4-1:0] adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bcd  <= '0;
        opnd <= opnd_in;
        cnt  <= nbits;
      end else if (busy) begin
        bcd  <= {adj[NDIG*4-2:0], opnd[W-1]};
        opnd <= {opnd[W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/ita_emit.sv
// Character emitter: drops leading zeros and sends one ASCII beat per digit.
`timescale 1ns / 1ps

module ita_emit #(
  parameter int NDIG = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ita_pkg::emit_ctl_t           ctl,
  input  logic [NDIG*4-1:0]            digits_in,
  output logic                         busy,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ita_pkg::CHAR_W-1:0]   m_tdata,
  output logic                         m_tlast
);

  localparam int DW = NDIG * 4;
  localparam int CW = $clog2(NDIG + 1);

  typedef enum logic [1:0] {E_IDLE, E_SKIP, E_SEND} emit_state_t;

  emit_state_t   state;
  logic [DW-1:0] digits;
  logic [CW-1:0] remain;
  logic          neg_pend;
  logic          upper;
  logic [3:0]    top_dig;
  logic          out_free;

  assign top_dig  = digits[DW-1 -: 4];
  assign out_free = !m_tvalid || m_tready;
  assign busy     = (state != E_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      m_tvalid <= 1'b0;
      neg_pend <= 1'b0;
    end else begin
      // While sending, the send branch below owns the valid flag.
      if (m_tvalid && m_tready && state != E_SEND) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        E_IDLE: begin
          if (ctl.load) begin
            digits   <= digits_in;
            remain   <= CW'(NDIG);
            neg_pend <= ctl.neg;
            upper    <= ctl.upper;
            state    <= E_SKIP;
          end
        end
        E_SKIP: begin
          // The last digit stays even when it is zero.
          if (top_dig == 4'd0 && remain > CW'(1)) begin
            digits <= {digits[DW-5:0], 4'b0000};
            remain <= remain - 1'b1;
          end else begin
            state <= E_SEND;
          end
        end
        E_SEND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (neg_pend) begin
              m_tdata  <= ita_pkg::CHAR_MINUS;
              m_tlast  <= 1'b0;
              neg_pend <= 1'b0;
            end else begin
              m_tdata <= ita_pkg::digit_char(top_dig, upper);
              m_tlast <= (remain == CW'(1));
              digits  <= {digits[DW-5:0], 4'b0000};
              remain  <= remain - 1'b1;
              if (remain == CW'(1)) begin
                state <= E_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: hdl/ita_checker.sv
// Port-level checks for the integer to ASCII digit converter, bound to the top.
`timescale 1ns / 1ps

module ita_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ita_pkg::CHAR_W-1:0]   m_tdata,
  input logic                         m_tlast
);

  // A stalled output beat holds its character and marker.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // The block is ready for a number right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("not ready after reset");

  // Only one number is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second number accepted while converting");

  // A minus sign is always followed by digits.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == ita_pkg::CHAR_MINUS) |-> !m_tlast)
    else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_digits ita_checker u_ita_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: bench/integer_to_ascii_digits_test.sv
// Self-checking testbench for the integer to ASCII digit converter.
`timescale 1ns / 1ps

module integer_to_ascii_digits_test;

  localparam int CHAR_W       = ita_pkg::CHAR_W;
  localparam int DATA_W       = ita_pkg::DATA_W;
  localparam int USER_W       = ita_pkg::USER_W;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Extra wait after the last expected character, so that a straggler beat
  // still reaches the scoreboard.
  localparam int SETTLE_TICKS = 120;
  localparam int REPORT_MAX   = 10;

  // One expected output beat: the character and its end-of-number flag.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [63:0] value
  logic [USER_W-1:0] s_tuser = '0;   // [1:0] op, [2] wide
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [CHAR_W-1:0] m_tdata;        // [7:0] ascii_char
  logic              m_tlast;

  char_beat_t pending_chars[$];
  int         fault_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_request = 0;

  integer_to_ascii_digits i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_ascii_digits verification failed");
      $finish;
    end
  end

  // Works out the characters one number should produce and queues them.
  function automatic void predict_digits(input logic [1:0] op, input logic wide,
                                         input logic [63:0] value);
    logic [63:0]       mag;
    logic [63:0]       mask;
    logic [63:0]       radix;
    logic [3:0]        digit;
    logic [CHAR_W-1:0] letter;
    logic [CHAR_W-1:0] digits[$];
    int                used_bits;
    bit                is_hex;
    is_hex    = (op == ita_pkg::OP_HEX_L) || (op == ita_pkg::OP_HEX_U);
    used_bits = (is_hex || wide) ? 64 : 32;
    mask      = (used_bits == 64) ? '1 : 64'h0000_0000_FFFF_FFFF;
    radix     = is_hex ? 64'd16 : 64'd10;
    mag       = value & mask;
    // Signed mode: the sign bit of the used width selects a minus sign and
    // the two's complement magnitude; the most negative value wraps onto
    // itself and prints as an unsigned power of two.
    if (op == ita_pkg::OP_SDEC && mag[used_bits-1]) begin
      pending_chars.push_back(char_beat_t'{ch: ita_pkg::CHAR_MINUS, last: 1'b0});
      mag = (~mag + 64'd1) & mask;
    end
    do begin
      digit = 4'(mag % radix);
      if (digit < 4'd10) begin
        digits.push_front(ita_pkg::CHAR_ZERO + CHAR_W'(digit));
      end else begin
        letter = (op == ita_pkg::OP_HEX_L) ? ita_pkg::CHAR_LOWER : ita_pkg::CHAR_UPPER;
        digits.push_front(letter + CHAR_W'(digit - 4'd10));
      end
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[i]) begin
      pending_chars.push_back(char_beat_t'{ch: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0, 1: return raw;
      2: return raw >> $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 120));
      // Around the 32-bit sign boundary, with junk in the upper half.
      4: return {raw[63:32], 32'h7FFF_FFFE + 32'($urandom_range(0, 3))};
      5: return 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(0, 3));
      default: return ~64'($urandom_range(0, 120));
    endcase
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Offers one number after a random idle gap and records its expected
  // characters once the block takes the beat.
  task automatic send_number(input logic [1:0] op, input logic wide, input logic [63:0] value);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      s_tuser  <= USER_W'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= {wide, op};
    do @(posedge clk); while (!s_tready);
    predict_digits(op, wide, value);
  endtask

  task automatic send_random_number();
    send_number(2'($urandom_range(ita_pkg::OP_SDEC, ita_pkg::OP_HEX_U)),
                1'($urandom), random_value());
  endtask

  // Drops the input and waits until every expected character has arrived.
  task automatic wait_all_delivered();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin : receiver
    int hold_left;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every output beat is checked against the oldest expected character.
  always @(posedge clk) begin : scoreboard
    char_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        report_fault($sformatf("unexpected character %h last %b", m_tdata, m_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.ch) begin
          report_fault($sformatf("character expected %h got %h", want.ch, m_tdata));
        end
        if (m_tlast !== want.last) begin
          report_fault($sformatf("tlast on %h expected %b got %b", want.ch, want.last, m_tlast));
        end
      end
    end
  end

  // Zero, the sign boundaries of both widths, the longest numbers, every mode.
  task automatic test_directed_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_number(ita_pkg::OP_SDEC,  1'b1, 64'd0);
    send_number(ita_pkg::OP_SDEC,  1'b1, 64'h8000_0000_0000_0000);
    send_number(ita_pkg::OP_SDEC,  1'b1, '1);
    send_number(ita_pkg::OP_SDEC,  1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(ita_pkg::OP_SDEC,  1'b1, 64'hFFFF_FFFF_FFFF_FFF6);
    send_number(ita_pkg::OP_SDEC,  1'b0, 64'hFFFF_FFFF_8000_0000);
    send_number(ita_pkg::OP_SDEC,  1'b0, 64'h1234_5678_7FFF_FFFF);
    send_number(ita_pkg::OP_SDEC,  1'b0, 64'hFFFF_FFFF_0000_0000);
    send_number(ita_pkg::OP_SDEC,  1'b0, 64'd9);
    send_number(ita_pkg::OP_UDEC,  1'b1, '1);
    send_number(ita_pkg::OP_UDEC,  1'b0, '1);
    send_number(ita_pkg::OP_UDEC,  1'b1, 64'd0);
    send_number(ita_pkg::OP_UDEC,  1'b1, 64'd10);
    send_number(ita_pkg::OP_UDEC,  1'b1, 64'd10000000000000000000);
    send_number(ita_pkg::OP_UDEC,  1'b0, 64'h8000_0000_8000_0000);
    send_number(ita_pkg::OP_HEX_L, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_number(ita_pkg::OP_HEX_U, 1'b1, 64'h0123_4567_89AB_CDEF);
    send_number(ita_pkg::OP_HEX_L, 1'b0, 64'hFEDC_BA98_7654_3210);
    send_number(ita_pkg::OP_HEX_U, 1'b0, 64'd0);
    send_number(ita_pkg::OP_HEX_U, 1'b1, '1);
    send_number(ita_pkg::OP_HEX_L, 1'b1, 64'hF);
    send_number(ita_pkg::OP_HEX_L, 1'b1, 64'h10);
    wait_all_delivered();
  endtask

  task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_number();
    wait_all_delivered();
  endtask

  // The receiver holds off while numbers keep coming, so the output register
  // fills and the block must stall its input until the hold is released.
  task automatic test_receiver_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    hold_request = 400;
    repeat (12) send_random_number();
    wait_all_delivered();
  endtask

  // The sender stops completely until the output side is empty, then resumes.
  task automatic test_pause_until_drained();
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    repeat (3) begin
      repeat (4) send_random_number();
      wait_all_delivered();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_random_stream(85, 0, 0);
    test_random_stream(85, 56, 0);
    test_random_stream(85, 0, 56);
    test_random_stream(85, 23, 23);
    test_receiver_hold_off();
    test_pause_until_drained();
    recv_stall_pct = 0;
    wait_all_delivered();
    if (fault_count == 0) begin
      $display("integer_to_ascii_digits verification clean");
    end else begin
      $display("integer_to_ascii_digits verification failed");
    end
    $finish;
  end

endmodule
